/* src/prt_pkg.sv */
`default_nettype none

package prt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Register file geometry
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int TIMEOUT_W   = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd120;

    // Register indexes (paddr[2] selects the register)
    localparam logic REG_TIMEOUT = 1'b0;

    // Item actions; code 3 is unused and does nothing
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_FETCH = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_APPEND,
        S_FINISH
    } state_t;

    // Input word
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] request_id;
        logic [5:0]  proc_tag;
        logic [31:0] handler_tag;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic             found;
        logic [31:0]      handler_out;
        logic [1:0]       status;
        logic [CNT_W-1:0] occupancy;
    } out_word_t;

    // One table entry as held in the memory
    typedef struct packed {
        logic [31:0] id;
        logic [5:0]  tag;
        logic [31:0] handle;
        logic [31:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

/* src/pending_request_table_with_timeout.sv */
`default_nettype none

// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+---------------------------
// in       | input     | in_valid / in_stall   | in_data  (in_word_t)
// out      | output    | out_valid / out_stall | out_data (out_word_t)
// apb      | input     | psel/penable/pready   | timeout_seconds at 0x0
//
// One item at a time, taken only in S_IDLE. A tick, an unused action or a fetch on an empty
// table goes S_START, S_FINISH; an untagged add or an add to an empty table goes S_START,
// S_APPEND, S_FINISH. A tagged add or a fetch walks the entry memory, S_READ then S_EVAL
// (evaluate and write back) for each entry; a fetch sweeps, matches and compacts in one pass.
// Reset clears the count and the seconds counter and loads the timeout with 120; the entry
// memory is not cleared. A finished word waits in the output register while out_stall is high.
module pending_request_table_with_timeout (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire prt_pkg::in_word_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output prt_pkg::out_word_t                   out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [prt_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [prt_pkg::PDATA_W-1:0]     pwdata,
    output logic [prt_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);
    import prt_pkg::*;

    // Control and datapath registers
    state_t                state_reg, state_next;
    in_word_t              item_reg, item_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [31:0]           now_reg, now_next;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      wr_reg, wr_next;
    logic                  found_reg, found_next;
    logic [31:0]           hout_reg, hout_next;
    logic                  full_reg, full_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_reg, out_next;

    // Entry memory
    entry_t                mem [TABLE_DEPTH];
    entry_t                rdata_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    entry_t                mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;

    // Decode helpers
    logic                  out_free;
    logic                  last_entry;
    logic                  tag_hit;
    logic                  id_hit;
    logic                  expired;
    logic [31:0]           age;
    logic                  cfg_write;

    assign out_free   = !out_valid_reg || !out_stall;
    assign last_entry = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign tag_hit    = rdata_reg.tag == item_reg.proc_tag;
    assign id_hit     = rdata_reg.id == item_reg.request_id;
    assign age        = now_reg - rdata_reg.stamp;
    assign expired    = age > {16'd0, timeout_reg};

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write && paddr[2] == REG_TIMEOUT)
        begin
            timeout_reg <= pwdata[TIMEOUT_W-1:0];
        end
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (item_reg.action == ACT_ADD)
                begin
                    if (item_reg.proc_tag == '0 || count_reg == '0)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else if (item_reg.action == ACT_FETCH)
                begin
                    state_next = (count_reg == '0) ? S_FINISH : S_READ;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (item_reg.action == ACT_ADD)
                begin
                    if (tag_hit)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (last_entry)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    state_next = last_entry ? S_FINISH : S_READ;
                end
            end
            S_APPEND:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        item_next      = item_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        found_next     = found_reg;
        hout_next      = hout_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_raddr      = idx_reg;
        mem_wdata      = '{id:     item_reg.request_id,
                           tag:    item_reg.proc_tag,
                           handle: item_reg.handler_tag,
                           stamp:  now_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                end
            end
            S_START:
            begin
                // clear per-item scratch; advance the clock on a tick
                idx_next   = '0;
                wr_next    = '0;
                found_next = 1'b0;
                hout_next  = '0;
                full_next  = 1'b0;
                if (item_reg.action == ACT_TICK)
                begin
                    now_next = now_reg + 32'd1;
                end
            end
            S_READ:
            begin
                mem_raddr = idx_reg;
            end
            S_EVAL:
            begin
                if (item_reg.action == ACT_ADD)
                begin
                    // overwrite the first entry with the same tag in place
                    if (tag_hit)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                    end
                    idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    // drop stale entries, take the first id match, compact the rest
                    mem_wdata = rdata_reg;
                    if (!expired)
                    begin
                        if (!found_reg && id_hit)
                        begin
                            found_next = 1'b1;
                            hout_next  = rdata_reg.handle;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = wr_reg[IDX_W-1:0];
                            wr_next   = wr_reg + CNT_W'(1);
                        end
                    end
                    idx_next = idx_reg + IDX_W'(1);
                    if (last_entry)
                    begin
                        count_next = wr_next;
                    end
                end
            end
            S_APPEND:
            begin
                if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                // load the result word once the output register is free
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.found       = found_reg;
                    out_next.handler_out = hout_reg;
                    out_next.occupancy   = count_reg;
                    if (item_reg.action == ACT_FETCH && !found_reg)
                    begin
                        out_next.status = ST_MISS;
                    end
                    else if (full_reg)
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        out_next.status = ST_DONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        wr_reg    <= wr_next;
        found_reg <= found_next;
        hout_reg  <= hout_next;
        full_reg  <= full_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire
